// File: rtl/btb_pkg.sv
package btb_pkg;

    localparam int MAX_DIGITS    = 10;
    localparam int VALUE_W       = 32;
    localparam int DIGIT_W       = 4;
    localparam int CNT_W         = 4;
    localparam int BCD_W         = MAX_DIGITS * DIGIT_W;
    localparam int LIMIT_W       = 34;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);

    localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = CNT_W'(3);

    // Classified transaction sitting in the queue between front and back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   ndig;
        logic               overflow;
    } job_t;

    // Converted transaction handed from the converter to the digit scanner
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] ndig;
        logic             overflow;
    } conv_res_t;

    // Clamp the programmed digit count to 1..MAX_DIGITS
    function automatic logic [CNT_W-1:0] sat_digits(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == CNT_W'(0)) begin
            r = CNT_W'(1);
        end
        else if (n > CNT_W'(MAX_DIGITS)) begin
            r = CNT_W'(MAX_DIGITS);
        end
        return r;
    endfunction

    // 10^n for n = 1..10
    function automatic logic [LIMIT_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [LIMIT_W-1:0] r;
        unique case (n)
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            4'd9:    r = 34'd1000000000;
            4'd10:   r = 34'd10000000000;
            default: r = 34'd10;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/btb_if.sv
interface btb_in_if;
    logic                          valid;
    logic                          ready;
    logic [btb_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface btb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [btb_pkg::CNT_W-1:0]   digit_count;

    modport source (output valid, output digit_count, input ready);
    modport sink   (input valid, input digit_count, output ready);
endinterface

interface btb_out_if;
    logic                          valid;
    logic                          ready;
    logic [btb_pkg::CNT_W-1:0]     digit_position;
    logic [btb_pkg::DIGIT_W-1:0]   bcd_digit;
    logic                          overflow;
    logic                          last;

    modport source (output valid, output digit_position, output bcd_digit,
                    output overflow, output last, input ready);
    modport sink   (input valid, input digit_position, input bcd_digit,
                    input overflow, input last, output ready);
endinterface

// File: rtl/btb_front.sv
module btb_front (
    input  logic            clk,
    input  logic            rst_n,
    btb_in_if.sink          samples,
    btb_cfg_if.sink         cfg,
    input  logic            q_full,
    output logic            q_push,
    output btb_pkg::job_t   q_job
);

    logic [btb_pkg::CNT_W-1:0] digit_count_reg;
    logic [btb_pkg::CNT_W-1:0] ndig;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= btb_pkg::DIGIT_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            digit_count_reg <= cfg.digit_count;
        end
    end

    // Overflow check against 10^n, done once per transaction at entry
    assign ndig          = btb_pkg::sat_digits(digit_count_reg);
    assign samples.ready = !q_full;
    assign q_push        = samples.valid && !q_full;
    assign q_job.value   = samples.value;
    assign q_job.ndig    = ndig;
    assign q_job.overflow =
        ({(btb_pkg::LIMIT_W - btb_pkg::VALUE_W)'(0), samples.value} >= btb_pkg::pow10(ndig));

endmodule

// File: rtl/btb_queue.sv
module btb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  btb_pkg::job_t   push_job,
    output logic            full,
    input  logic            pop,
    output btb_pkg::job_t   pop_job,
    output logic            not_empty
);

    btb_pkg::job_t entries [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/btb_conv.sv
module btb_conv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  btb_pkg::job_t        q_job,
    output logic                 q_pop,
    output logic                 res_valid,
    output btb_pkg::conv_res_t   res,
    input  logic                 res_take
);

    typedef enum logic {C_IDLE, C_BUSY} conv_state_t;

    conv_state_t                      state_reg;
    logic [btb_pkg::STEP_CNT_W-1:0]   step_reg;
    logic [btb_pkg::BCD_W-1:0]        bcd_reg;
    logic [btb_pkg::VALUE_W-1:0]      bin_reg;
    logic [btb_pkg::CNT_W-1:0]        ndig_reg;
    logic                             res_valid_reg;
    btb_pkg::conv_res_t               res_reg;
    logic [btb_pkg::BCD_W-1:0]        bcd_next;
    logic [btb_pkg::VALUE_W-1:0]      bin_next;
    logic                             res_load;

    // Shift-and-add-3, four bits per cycle
    always_comb
    begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int s = 0; s < btb_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < btb_pkg::MAX_DIGITS; d++)
            begin
                if (bcd_next[d*btb_pkg::DIGIT_W +: btb_pkg::DIGIT_W] >= 4'd5)
                begin
                    bcd_next[d*btb_pkg::DIGIT_W +: btb_pkg::DIGIT_W] =
                        bcd_next[d*btb_pkg::DIGIT_W +: btb_pkg::DIGIT_W] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next[btb_pkg::BCD_W-2:0], bin_next, 1'b0};
        end
    end

    assign q_pop     = (state_reg == C_IDLE) && q_valid && (!res_valid_reg || res_take);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Result slot is filled by an overflow pop or by the last conversion step
    assign res_load  = (q_pop && q_job.overflow)
                    || ((state_reg == C_BUSY)
                        && (step_reg == btb_pkg::STEP_CNT_W'(btb_pkg::CONV_STEPS - 1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                C_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_job.overflow)
                        begin
                            // Nothing to convert: hand over the flag right away
                            res_reg.bcd      <= '0;
                            res_reg.ndig     <= q_job.ndig;
                            res_reg.overflow <= 1'b1;
                        end
                        else
                        begin
                            bin_reg   <= q_job.value;
                            bcd_reg   <= '0;
                            ndig_reg  <= q_job.ndig;
                            step_reg  <= '0;
                            state_reg <= C_BUSY;
                        end
                    end
                end
                C_BUSY:
                begin
                    bcd_reg  <= bcd_next;
                    bin_reg  <= bin_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == btb_pkg::STEP_CNT_W'(btb_pkg::CONV_STEPS - 1))
                    begin
                        res_reg.bcd      <= bcd_next;
                        res_reg.ndig     <= ndig_reg;
                        res_reg.overflow <= 1'b0;
                        state_reg        <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/btb_emit.sv
module btb_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  btb_pkg::conv_res_t   res,
    output logic                 res_take,
    btb_out_if.source            digits
);

    typedef enum logic {E_IDLE, E_SCAN} emit_state_t;

    emit_state_t                     state_reg;
    logic [btb_pkg::BCD_W-1:0]       bcd_reg;
    logic [btb_pkg::CNT_W-1:0]       ndig_reg;
    logic                            ovf_reg;
    logic [btb_pkg::CNT_W-1:0]       pos_reg;
    logic                            out_valid_reg;
    logic [btb_pkg::CNT_W-1:0]       out_pos_reg;
    logic [btb_pkg::DIGIT_W-1:0]     out_bcd_reg;
    logic                            out_ovf_reg;
    logic                            out_last_reg;
    logic                            out_free;
    logic                            out_load;
    logic                            is_last;
    logic [btb_pkg::CNT_W-1:0]       nib_idx;

    assign res_take = res_valid && (state_reg == E_IDLE);
    assign out_free = !out_valid_reg || digits.ready;
    assign out_load = (state_reg == E_SCAN) && out_free;
    assign is_last  = ovf_reg || (pos_reg == ndig_reg - 4'd1);
    // Most significant digit first: position 0 reads nibble ndig-1
    assign nib_idx  = ndig_reg - 4'd1 - pos_reg;

    assign digits.valid          = out_valid_reg;
    assign digits.digit_position = out_pos_reg;
    assign digits.bcd_digit      = out_bcd_reg;
    assign digits.overflow       = out_ovf_reg;
    assign digits.last           = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && digits.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                E_IDLE:
                begin
                    if (res_take)
                    begin
                        bcd_reg   <= res.bcd;
                        ndig_reg  <= res.ndig;
                        ovf_reg   <= res.overflow;
                        pos_reg   <= '0;
                        state_reg <= E_SCAN;
                    end
                end
                E_SCAN:
                begin
                    if (out_free)
                    begin
                        out_pos_reg   <= pos_reg;
                        out_ovf_reg   <= ovf_reg;
                        out_last_reg  <= is_last;
                        out_bcd_reg   <= ovf_reg ? '0 :
                            bcd_reg[nib_idx*btb_pkg::DIGIT_W +: btb_pkg::DIGIT_W];
                        pos_reg       <= pos_reg + 4'd1;
                        if (is_last)
                        begin
                            state_reg <= E_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/binary_to_bcd_digit_scan.sv
// Binary to BCD converter feeding a multiplexed digit display.
//
// Channels (valid/ready, a transaction moves when both are high):
//   samples : one 32-bit unsigned value per transaction.
//   cfg     : write of digit_count (number of digits shown, clamped 1..10).
//             Always ready; write it only while the block is idle.
//   digits  : one transaction per display digit, most significant first,
//             carrying digit_position, bcd_digit and last. A value that
//             does not fit in digit_count digits yields a single transaction
//             with overflow and last set.
// Digits go out one per cycle while the sink is ready. The double-dabble
// converter works 4 bits a cycle and takes a new value only once the last
// one is done; the digit scanner likewise takes a new result only when
// idle. A two-entry queue between the input side and the converter keeps
// samples ready while a conversion is under way.
// Reset: digit_count returns to 3, queue and pipeline are emptied.
// Receiver stall: the output register holds; the scanner, converter and
// queue fill up in turn, then samples.ready drops.
module binary_to_bcd_digit_scan (
    input  logic        clk,
    input  logic        rst_n,
    btb_in_if.sink      samples,
    btb_cfg_if.sink     cfg,
    btb_out_if.source   digits
);

    // Front to queue
    logic                 q_full;
    logic                 q_push;
    btb_pkg::job_t        q_in_job;

    // Queue to converter
    logic                 q_pop;
    logic                 q_not_empty;
    btb_pkg::job_t        q_out_job;

    // Converter to digit scanner
    logic                 res_valid;
    logic                 res_take;
    btb_pkg::conv_res_t   res;

    // Front: config register, overflow classification
    btb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_in_job)
    );

    btb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (q_out_job),
        .not_empty (q_not_empty)
    );

    // Back: iterative conversion, then digit-by-digit scan out
    btb_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_job     (q_out_job),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    btb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .digits    (digits)
    );

endmodule

// File: rtl/btb_checker.sv
module btb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [btb_pkg::CNT_W-1:0]     digit_position,
    input  logic [btb_pkg::DIGIT_W-1:0]   bcd_digit,
    input  logic                          overflow,
    input  logic                          last
);

    logic [btb_pkg::CNT_W-1:0] exp_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pos_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_pos_reg <= last ? '0 : exp_pos_reg + 4'd1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_position)
            && $stable(bcd_digit) && $stable(overflow) && $stable(last))
        else $error("digits changed while stalled");

    a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> last && bcd_digit == 4'd0
            && digit_position == 4'd0)
        else $error("overflow transaction malformed");

    a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bcd_digit <= 4'd9)
        else $error("bcd digit out of range");

    a_pos_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_position == exp_pos_reg)
        else $error("digit position out of sequence");

endmodule

bind binary_to_bcd_digit_scan btb_checker u_btb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (digits.valid),
    .out_ready      (digits.ready),
    .digit_position (digits.digit_position),
    .bcd_digit      (digits.bcd_digit),
    .overflow       (digits.overflow),
    .last           (digits.last)
);

// File: tb/btb_digit_check_pkg.sv
`timescale 1ns / 100ps

package btb_digit_check_pkg;

    // One digit transaction as seen on the output channel
    typedef struct packed {
        logic [btb_pkg::CNT_W-1:0]   digit_position;
        logic [btb_pkg::DIGIT_W-1:0] bcd_digit;
        logic                        overflow;
        logic                        last;
    } digit_xact_t;

    class digit_scoreboard;

        logic [btb_pkg::CNT_W-1:0] digit_count = btb_pkg::DIGIT_COUNT_RESET;
        digit_xact_t      expected_digits[$];
        int               errors = 0;
        int               values_seen = 0;
        int               digits_seen = 0;
        int               overflows_seen = 0;

        // Programmed count clamped into 1..MAX_DIGITS
        function int unsigned shown_digits();
            int unsigned n;
            n = digit_count;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > btb_pkg::MAX_DIGITS)
            begin
                n = btb_pkg::MAX_DIGITS;
            end
            return n;
        endfunction

        // Queue up the digit run that one accepted value must produce
        function void note_value(input logic [btb_pkg::VALUE_W-1:0] value);
            int unsigned       n;
            int unsigned       i;
            longint unsigned   limit;
            longint unsigned   rest;
            logic [btb_pkg::DIGIT_W-1:0] dig[btb_pkg::MAX_DIGITS];
            digit_xact_t       x;
            n = shown_digits();
            limit = 1;
            for (i = 0; i < n; i++)
            begin
                limit = limit * 10;
            end
            values_seen++;
            if (value >= limit)
            begin
                x.digit_position = '0;
                x.bcd_digit      = '0;
                x.overflow       = 1'b1;
                x.last           = 1'b1;
                expected_digits.push_back(x);
                overflows_seen++;
                return;
            end
            rest = value;
            for (i = 0; i < n; i++)
            begin
                dig[n - 1 - i] = btb_pkg::DIGIT_W'(rest % 10);
                rest = rest / 10;
            end
            for (i = 0; i < n; i++)
            begin
                x.digit_position = btb_pkg::CNT_W'(i);
                x.bcd_digit      = dig[i];
                x.overflow       = 1'b0;
                x.last           = (i + 1 == n);
                expected_digits.push_back(x);
            end
        endfunction

        function void flag(input string what);
            errors++;
            if (errors <= 10)
            begin
                $display("%0t ERROR %s", $realtime, what);
            end
        endfunction

        function string show(input digit_xact_t x);
            return $sformatf("pos %0d bcd %0d ovf %0b last %0b",
                             x.digit_position, x.bcd_digit, x.overflow, x.last);
        endfunction

        // Compare one accepted digit transaction against the oldest expectation
        function void check_digit(input logic [btb_pkg::CNT_W-1:0] position,
                                  input logic [btb_pkg::DIGIT_W-1:0] bcd,
                                  input logic ovf,
                                  input logic lst);
            digit_xact_t got;
            digit_xact_t want;
            got.digit_position = position;
            got.bcd_digit      = bcd;
            got.overflow       = ovf;
            got.last           = lst;
            digits_seen++;
            if (expected_digits.size() == 0)
            begin
                flag({"unexpected digit transaction: ", show(got)});
                return;
            end
            want = expected_digits.pop_front();
            if (got.digit_position !== want.digit_position
                || got.bcd_digit !== want.bcd_digit
                || got.overflow !== want.overflow
                || got.last !== want.last)
            begin
                flag({"mismatch: expected ", show(want), ", got ", show(got)});
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        function void drain_check();
            while (expected_digits.size() != 0)
            begin
                flag({"never received: ", show(expected_digits.pop_front())});
            end
        endfunction

    endclass

endpackage

// File: tb/binary_to_bcd_digit_scan_tb.sv
`timescale 1ns / 100ps

module binary_to_bcd_digit_scan_tb;

    logic clk;
    logic rst_n;

    btb_in_if  samples();
    btb_cfg_if cfg();
    btb_out_if digits();

    binary_to_bcd_digit_scan u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .digits  (digits)
    );

    btb_digit_check_pkg::digit_scoreboard scoreboard;

    // When set, neither side inserts idle cycles
    bit full_speed;
    int settings_written;

    // Digit-count sequence for the random phases; includes 0 and values
    // above the maximum so both clamps get exercised under load.
    logic [btb_pkg::CNT_W-1:0] phase_counts[13] = '{4'd10, 4'd1, 4'd0, 4'd15, 4'd5, 4'd3,
                                                    4'd8, 4'd2, 4'd11, 4'd9, 4'd6, 4'd4,
                                                    4'd7};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs; far above the slowest legal run
    initial
    begin
        #2000000;
        $display("binary_to_bcd_digit_scan_tb: errors");
        $finish;
    end

    // Present one value, idling first when a gap is drawn. valid is only lowered when
    // a gap is drawn, so back-to-back transactions keep it high.
    task automatic send_value(input logic [btb_pkg::VALUE_W-1:0] v);
        int gap;
        gap = full_speed ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.value <= v;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        scoreboard.note_value(v);
    endtask

    // Stop sending and wait until every queued digit has come out
    task automatic wait_idle();
        samples.valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_digit_count(input logic [btb_pkg::CNT_W-1:0] n);
        cfg.valid       <= 1'b1;
        cfg.digit_count <= n;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        scoreboard.digit_count = n;
        settings_written++;
        @(posedge clk);
    endtask

    // Mostly values that fit the current width, plus both sides of the
    // overflow boundary, tiny values and unrestricted 32-bit words.
    function automatic logic [btb_pkg::VALUE_W-1:0] pick_value(input int unsigned n);
        longint unsigned span;
        longint unsigned r;
        int              kind;
        span = 1;
        repeat (n) span = span * 10;
        kind = $urandom_range(0, 9);
        r = {$urandom, $urandom};
        if (kind <= 5)
        begin
            return btb_pkg::VALUE_W'(r % span);
        end
        else if (kind == 6)
        begin
            if (span > 64'hFFFF_FFFF)
            begin
                return '1;
            end
            return btb_pkg::VALUE_W'(span - $urandom_range(0, 1));
        end
        else if (kind == 7)
        begin
            return btb_pkg::VALUE_W'($urandom_range(0, 99));
        end
        return btb_pkg::VALUE_W'($urandom);
    endfunction

    // Output side: random backpressure per transaction, checks on acceptance
    initial
    begin
        int stall;
        digits.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = full_speed ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                digits.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            digits.ready <= 1'b1;
            @(posedge clk);
            while (!digits.valid) @(posedge clk);
            scoreboard.check_digit(digits.digit_position, digits.bcd_digit,
                                   digits.overflow, digits.last);
        end
    end

    // Main sequence
    initial
    begin
        int p;
        int k;
        scoreboard       = new;
        full_speed       = 1'b0;
        settings_written = 0;
        rst_n            = 1'b0;
        samples.valid    = 1'b0;
        samples.value    = '0;
        cfg.valid        = 1'b0;
        cfg.digit_count  = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset width of three digits, including the first overflow
        send_value(32'd0);
        send_value(32'd999);
        send_value(32'd1000);
        send_value(32'hFFFF_FFFF);
        send_value(32'd507);

        // Ten digits: every 32-bit value fits, the widest run
        wait_idle();
        write_digit_count(4'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        send_value(32'd1000000000);
        send_value(32'd999999999);

        // Single digit and its boundary
        wait_idle();
        write_digit_count(4'd1);
        send_value(32'd0);
        send_value(32'd9);
        send_value(32'd10);

        // Zero count behaves as one digit
        wait_idle();
        write_digit_count(4'd0);
        send_value(32'd9);
        send_value(32'd10);

        // All-ones count clamps to ten digits
        wait_idle();
        write_digit_count(4'd15);
        send_value(32'd4294967295);
        send_value(32'd1234567890);

        // Just above the maximum clamps as well
        wait_idle();
        write_digit_count(4'd11);
        send_value(32'd42);

        // Random phases, one digit count each; every fourth runs without idling
        for (p = 0; p < 13; p++)
        begin
            wait_idle();
            write_digit_count(phase_counts[p]);
            full_speed = (p % 4 == 2);
            for (k = 0; k < 17; k++)
            begin
                send_value(pick_value(scoreboard.shown_digits()));
                // Let the pipeline drain completely once mid-phase
                if (p == 4 && k == 8)
                begin
                    wait_idle();
                end
            end
        end

        full_speed = 1'b0;
        wait_idle();
        repeat (30) @(posedge clk);
        scoreboard.drain_check();

        $display("covered %0d values across %0d digit-count writes (clamps included)",
                 scoreboard.values_seen, settings_written);
        $display("received %0d digit transactions, %0d of them overflow results",
                 scoreboard.digits_seen, scoreboard.overflows_seen);
        if (scoreboard.errors == 0)
        begin
            $display("binary_to_bcd_digit_scan_tb: clean");
        end
        else
        begin
            $display("binary_to_bcd_digit_scan_tb: errors");
        end
        $finish;
    end

endmodule
